>>> sv/mip_level_address_calc_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mip level address calculator
// Implication checks clocked on clk and switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef MIP_LEVEL_ADDRESS_CALC_TOP_ASSERT_SVH
`define MIP_LEVEL_ADDRESS_CALC_TOP_ASSERT_SVH

// Same-cycle implication.
`define MLAC_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("mlac: same-cycle check failed");

// Next-cycle implication.
`define MLAC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mlac: next-cycle check failed");

`endif

>>> sv/mlac_pkg.sv
// ----------------------------------------------------------------------------
// mlac_pkg
// Widths, register indexes, shared types and helper functions.
// ----------------------------------------------------------------------------
package mlac_pkg;

  localparam int DIM_W   = 15;
  localparam int LVL_W   = 4;
  localparam int LEVELS  = 16;
  localparam int COORD_W = 14;
  localparam int FACE_W  = 3;
  localparam int EB_W    = 5;
  localparam int BPP_W   = 8;
  localparam int WORD_W  = 32;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 15;

  typedef enum logic [IDX_W-1:0] {
    REG_BASE_WIDTH     = 3'd0,
    REG_BASE_HEIGHT    = 3'd1,
    REG_BASE_DEPTH     = 3'd2,
    REG_HIGHEST_LEVEL  = 3'd3,
    REG_CUBE_EN        = 3'd4,
    REG_COMPRESSED     = 3'd5,
    REG_BLOCK_BYTES    = 3'd6,
    REG_BITS_PER_PIXEL = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0] base_width;
    logic [DIM_W-1:0] base_height;
    logic [DIM_W-1:0] base_depth;
    logic [LVL_W-1:0] highest_level;
    logic             cube_en;
    logic             compressed;
    logic [EB_W-1:0]  block_bytes;
    logic [BPP_W-1:0] bits_per_pixel;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    base_width:     15'd1,
    base_height:    15'd1,
    base_depth:     15'd1,
    highest_level:  4'd0,
    cube_en:        1'b0,
    compressed:     1'b0,
    block_bytes:    5'd8,
    bits_per_pixel: 8'd32
  };

  typedef struct packed {
    logic [FACE_W-1:0]  face;
    logic [LVL_W-1:0]   mip_level;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] level_offset;
    logic [WORD_W-1:0] level_size;
    logic [WORD_W-1:0] element_offset;
    logic [WORD_W-1:0] total_size;
    logic              out_of_range;
  } rsp_t;

  // Level table status seen by the item pipeline
  typedef struct packed {
    logic              ready;
    logic [WORD_W-1:0] total;
  } tbl_status_t;

  typedef enum logic [2:0] {
    TBL_WH,
    TBL_D,
    TBL_EB,
    TBL_ACC,
    TBL_IDLE
  } tbl_state_t;

  // Level extent: base >> lvl, floor of 1, optionally rounded up to 4x4 blocks
  function automatic logic [DIM_W-1:0] level_dim(input logic [DIM_W-1:0] base,
                                                 input logic [LVL_W-1:0] lvl,
                                                 input logic blocks);
    logic [DIM_W-1:0] v;
    logic [DIM_W:0]   r;
    v = base >> lvl;
    if (v == '0) v = DIM_W'(1);
    r = {1'b0, v} + (DIM_W+1)'(3);
    return blocks ? {1'b0, r[DIM_W:2]} : v;
  endfunction

  function automatic logic [EB_W-1:0] elem_bytes(input cfg_t c);
    return c.compressed ? c.block_bytes : c.bits_per_pixel[BPP_W-1:3];
  endfunction

endpackage

>>> sv/mlac_ifs.sv
// ----------------------------------------------------------------------------
// mlac channel interfaces
// Valid/ready channels for configuration, requests and responses.
// ----------------------------------------------------------------------------
interface mlac_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mlac_pkg::IDX_W-1:0]  index;
  logic [mlac_pkg::DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface mlac_req_if;
  logic                         valid;
  logic                         ready;
  logic [mlac_pkg::FACE_W-1:0]  face;
  logic [mlac_pkg::LVL_W-1:0]   mip_level;
  logic [mlac_pkg::COORD_W-1:0] coord_x;
  logic [mlac_pkg::COORD_W-1:0] coord_y;
  logic [mlac_pkg::COORD_W-1:0] coord_z;
  modport source (output valid, face, mip_level, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, face, mip_level, coord_x, coord_y, coord_z, output ready);
endinterface

interface mlac_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [mlac_pkg::WORD_W-1:0] level_offset;
  logic [mlac_pkg::WORD_W-1:0] level_size;
  logic [mlac_pkg::WORD_W-1:0] element_offset;
  logic [mlac_pkg::WORD_W-1:0] total_size;
  logic                        out_of_range;
  modport source (output valid, level_offset, level_size, element_offset, total_size,
                  out_of_range, input ready);
  modport sink   (input valid, level_offset, level_size, element_offset, total_size,
                  out_of_range, output ready);
endinterface

>>> sv/mlac_table.sv
// ----------------------------------------------------------------------------
// mlac_table
// Builds per-level face sizes, prefix offsets and the total image size.
// ----------------------------------------------------------------------------
module mlac_table (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  mlac_pkg::cfg_t                      cfg_regs,
  input  logic [mlac_pkg::LVL_W-1:0]          top_level,
  input  logic [mlac_pkg::LVL_W-1:0]          rd_level,
  output logic [mlac_pkg::WORD_W-1:0]         rd_prefix,
  output logic [mlac_pkg::WORD_W-1:0]         rd_size,
  output mlac_pkg::tbl_status_t               status
);

  mlac_pkg::tbl_state_t             state, state_next;
  logic [mlac_pkg::LVL_W-1:0]       lv, lv_next;

  logic [mlac_pkg::DIM_W-1:0]       d_q;
  logic [mlac_pkg::WORD_W-1:0]      work;
  logic [mlac_pkg::WORD_W-1:0]      acc;
  logic [mlac_pkg::WORD_W-1:0]      total;
  logic [mlac_pkg::WORD_W-1:0]      sizes    [mlac_pkg::LEVELS];
  logic [mlac_pkg::WORD_W-1:0]      prefixes [mlac_pkg::LEVELS];

  logic [mlac_pkg::DIM_W-1:0]       w_c, h_c, d_c;
  logic [2*mlac_pkg::DIM_W-1:0]     wh_c;
  logic [3*mlac_pkg::DIM_W-1:0]     whd_c;
  logic [mlac_pkg::WORD_W+mlac_pkg::EB_W-1:0] sz_c;
  logic [mlac_pkg::WORD_W-1:0]      acc_base, face_bytes, acc_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlac_pkg::TBL_WH;
      lv    <= '0;
    end else begin
      state <= state_next;
      lv    <= lv_next;
    end
  end

  always_comb begin
    state_next = state;
    lv_next    = lv;
    case (state)
      mlac_pkg::TBL_WH:  state_next = mlac_pkg::TBL_D;
      mlac_pkg::TBL_D:   state_next = mlac_pkg::TBL_EB;
      mlac_pkg::TBL_EB:  state_next = mlac_pkg::TBL_ACC;
      mlac_pkg::TBL_ACC: begin
        if (lv == mlac_pkg::LVL_W'(mlac_pkg::LEVELS - 1)) begin
          state_next = mlac_pkg::TBL_IDLE;
        end else begin
          state_next = mlac_pkg::TBL_WH;
          lv_next    = lv + mlac_pkg::LVL_W'(1);
        end
      end
      mlac_pkg::TBL_IDLE: state_next = mlac_pkg::TBL_IDLE;
      default:            state_next = mlac_pkg::TBL_WH;
    endcase
    if (start) begin
      state_next = mlac_pkg::TBL_WH;
      lv_next    = '0;
    end
  end

  // datapath: at most one multiply per phase
  always_comb begin
    w_c   = mlac_pkg::level_dim(cfg_regs.base_width,  lv, cfg_regs.compressed);
    h_c   = mlac_pkg::level_dim(cfg_regs.base_height, lv, cfg_regs.compressed);
    d_c   = mlac_pkg::level_dim(cfg_regs.base_depth,  lv, 1'b0);
    wh_c  = (2*mlac_pkg::DIM_W)'(w_c) * (2*mlac_pkg::DIM_W)'(h_c);
    whd_c = (3*mlac_pkg::DIM_W)'(work[2*mlac_pkg::DIM_W-1:0])
            * (3*mlac_pkg::DIM_W)'(d_q);
    sz_c  = (mlac_pkg::WORD_W+mlac_pkg::EB_W)'(work)
            * (mlac_pkg::WORD_W+mlac_pkg::EB_W)'(mlac_pkg::elem_bytes(cfg_regs));
    acc_base   = (lv == '0) ? '0 : acc;
    // six faces: 4x + 2x
    face_bytes = cfg_regs.cube_en ? ({work[mlac_pkg::WORD_W-3:0], 2'b00}
                                     + {work[mlac_pkg::WORD_W-2:0], 1'b0})
                                  : work;
    acc_new    = acc_base + face_bytes;
  end

  always_ff @(posedge clk) begin
    case (state)
      mlac_pkg::TBL_WH: begin
        work <= mlac_pkg::WORD_W'(wh_c);
        d_q  <= d_c;
      end
      mlac_pkg::TBL_D:  work <= whd_c[mlac_pkg::WORD_W-1:0];
      mlac_pkg::TBL_EB: work <= sz_c[mlac_pkg::WORD_W-1:0];
      mlac_pkg::TBL_ACC: begin
        sizes[lv]    <= work;
        prefixes[lv] <= acc_base;
        acc          <= acc_new;
        if (lv == top_level) total <= acc_new;
      end
      default: ;
    endcase
  end

  assign rd_prefix    = prefixes[rd_level];
  assign rd_size      = sizes[rd_level];
  assign status.ready = (state == mlac_pkg::TBL_IDLE);
  assign status.total = total;

endmodule

>>> sv/mlac_pipe.sv
// ----------------------------------------------------------------------------
// mlac_pipe
// Four-stage request pipeline: decode, z*h+y, *w+x, byte scaling.
// ----------------------------------------------------------------------------
module mlac_pipe (
  input  logic                         clk,
  input  logic                         rst,
  input  mlac_pkg::cfg_t               cfg_regs,
  input  logic [mlac_pkg::LVL_W-1:0]   top_level,
  input  mlac_pkg::tbl_status_t        tbl_stat,
  input  logic [mlac_pkg::WORD_W-1:0]  rd_prefix,
  input  logic [mlac_pkg::WORD_W-1:0]  rd_size,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  mlac_pkg::req_t               req_data,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output mlac_pkg::rsp_t               rsp_data
);

  localparam int P1_W = mlac_pkg::COORD_W + mlac_pkg::DIM_W + 1;

  logic en;
  logic v1, v2, v3, v4;

  logic [mlac_pkg::DIM_W-1:0]   w_in, h_in, d_in;
  logic                         oor_in;

  logic [mlac_pkg::FACE_W-1:0]  face1, face2, face3;
  logic [mlac_pkg::COORD_W-1:0] x1, y1, z1, x2;
  logic [mlac_pkg::DIM_W-1:0]   w1, h1, w2;
  logic [mlac_pkg::WORD_W-1:0]  pre1, pre2, pre3, size1, size2, size3;
  logic                         oor1, oor2, oor3;
  logic [P1_W-1:0]              p1;
  logic [mlac_pkg::WORD_W-1:0]  p2;
  mlac_pkg::rsp_t               rsp_q;

  logic [P1_W-1:0]                            zh_c;
  logic [P1_W+mlac_pkg::DIM_W-1:0]            pw_c;
  logic [mlac_pkg::WORD_W+mlac_pkg::EB_W-1:0] eo_c;
  logic [mlac_pkg::WORD_W+mlac_pkg::FACE_W-1:0] sf_c;

  assign en        = !v4 || rsp_ready;
  assign req_ready = en && tbl_stat.ready;

  always_comb begin
    w_in   = mlac_pkg::level_dim(cfg_regs.base_width,  req_data.mip_level, cfg_regs.compressed);
    h_in   = mlac_pkg::level_dim(cfg_regs.base_height, req_data.mip_level, cfg_regs.compressed);
    d_in   = mlac_pkg::level_dim(cfg_regs.base_depth,  req_data.mip_level, 1'b0);
    oor_in = (req_data.mip_level > top_level)
             || ({1'b0, req_data.coord_x} >= w_in)
             || ({1'b0, req_data.coord_y} >= h_in)
             || ({1'b0, req_data.coord_z} >= d_in);
    zh_c = P1_W'(z1) * P1_W'(h1) + P1_W'(y1);
    pw_c = (P1_W+mlac_pkg::DIM_W)'(p1) * (P1_W+mlac_pkg::DIM_W)'(w2);
    eo_c = (mlac_pkg::WORD_W+mlac_pkg::EB_W)'(p2)
           * (mlac_pkg::WORD_W+mlac_pkg::EB_W)'(mlac_pkg::elem_bytes(cfg_regs));
    sf_c = (mlac_pkg::WORD_W+mlac_pkg::FACE_W)'(size3)
           * (mlac_pkg::WORD_W+mlac_pkg::FACE_W)'(face3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid && req_ready;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      face1 <= req_data.face;
      x1    <= req_data.coord_x;
      y1    <= req_data.coord_y;
      z1    <= req_data.coord_z;
      w1    <= w_in;
      h1    <= h_in;
      pre1  <= rd_prefix;
      size1 <= rd_size;
      oor1  <= oor_in;

      face2 <= face1;
      x2    <= x1;
      w2    <= w1;
      p1    <= zh_c;
      pre2  <= pre1;
      size2 <= size1;
      oor2  <= oor1;

      face3 <= face2;
      p2    <= pw_c[mlac_pkg::WORD_W-1:0] + mlac_pkg::WORD_W'(x2);
      pre3  <= pre2;
      size3 <= size2;
      oor3  <= oor2;

      rsp_q.level_offset   <= pre3 + sf_c[mlac_pkg::WORD_W-1:0];
      rsp_q.level_size     <= size3;
      rsp_q.element_offset <= eo_c[mlac_pkg::WORD_W-1:0];
      rsp_q.total_size     <= tbl_stat.total;
      rsp_q.out_of_range   <= oor3;
    end
  end

  assign rsp_valid = v4;
  assign rsp_data  = rsp_q;

endmodule

>>> sv/mip_level_address_calc_top.sv
// ----------------------------------------------------------------------------
// mip_level_address_calc_top
// Texture mip chain address unit: level offset, level size, element offset
// and total image size for one face/level/coordinate request.
// ----------------------------------------------------------------------------
//
//  channel | dir | transaction carries
//  --------+-----+--------------------------------------------------------
//  cfg     | in  | index, data: one configuration register write
//  req     | in  | face, mip_level, coord_x, coord_y, coord_z
//  rsp     | out | level_offset, level_size, element_offset, total_size,
//          |     | out_of_range
//
//  One request per cycle is taken once the level table is built and rsp is
//  not stalled. Four register stages (decode, z*h+y, *w+x, *bytes) lie between
//  a req transaction and its rsp transaction.
//  After reset and after every cfg transaction the level table is rebuilt:
//  16 levels, each through the steps w*h, *d, *bytes and accumulate;
//  req.ready is low until the build is done.
//  cfg.ready is always high. A stalled rsp freezes the whole pipeline.
//
module mip_level_address_calc_top #(
  parameter int MAX_LEVELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  mlac_cfg_if.sink    cfg,
  mlac_req_if.sink    req,
  mlac_rsp_if.source  rsp
);

  `include "mip_level_address_calc_top_assert.svh"

  mlac_pkg::cfg_t                  cfg_regs;
  logic                            cfg_wr;
  logic [mlac_pkg::LVL_W-1:0]      top_level;
  mlac_pkg::tbl_status_t           tbl_stat;
  logic [mlac_pkg::WORD_W-1:0]     rd_prefix, rd_size;
  mlac_pkg::req_t                  req_data;
  mlac_pkg::rsp_t                  rsp_data;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  // Register file; every write restarts the level table build
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= mlac_pkg::CFG_RESET;
    end else if (cfg_wr) begin
      case (mlac_pkg::reg_idx_t'(cfg.index))
        mlac_pkg::REG_BASE_WIDTH:     cfg_regs.base_width     <= cfg.data[mlac_pkg::DIM_W-1:0];
        mlac_pkg::REG_BASE_HEIGHT:    cfg_regs.base_height    <= cfg.data[mlac_pkg::DIM_W-1:0];
        mlac_pkg::REG_BASE_DEPTH:     cfg_regs.base_depth     <= cfg.data[mlac_pkg::DIM_W-1:0];
        mlac_pkg::REG_HIGHEST_LEVEL:  cfg_regs.highest_level  <= cfg.data[mlac_pkg::LVL_W-1:0];
        mlac_pkg::REG_CUBE_EN:        cfg_regs.cube_en        <= cfg.data[0];
        mlac_pkg::REG_COMPRESSED:     cfg_regs.compressed     <= cfg.data[0];
        mlac_pkg::REG_BLOCK_BYTES:    cfg_regs.block_bytes    <= cfg.data[mlac_pkg::EB_W-1:0];
        mlac_pkg::REG_BITS_PER_PIXEL: cfg_regs.bits_per_pixel <= cfg.data[mlac_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // Last stored level, clamped to the table depth the build supports
  assign top_level = (32'(cfg_regs.highest_level) >= MAX_LEVELS)
                     ? mlac_pkg::LVL_W'(MAX_LEVELS - 1) : cfg_regs.highest_level;

  assign req_data = '{
    face:      req.face,
    mip_level: req.mip_level,
    coord_x:   req.coord_x,
    coord_y:   req.coord_y,
    coord_z:   req.coord_z
  };

  // Per-level sizes and prefix offsets depend on configuration only
  mlac_table u_table (
    .clk       (clk),
    .rst       (rst),
    .start     (cfg_wr),
    .cfg_regs  (cfg_regs),
    .top_level (top_level),
    .rd_level  (req.mip_level),
    .rd_prefix (rd_prefix),
    .rd_size   (rd_size),
    .status    (tbl_stat)
  );

  // Per-request element offset and result assembly
  mlac_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg_regs  (cfg_regs),
    .top_level (top_level),
    .tbl_stat  (tbl_stat),
    .rd_prefix (rd_prefix),
    .rd_size   (rd_size),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_data  (req_data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp_data)
  );

  assign rsp.level_offset   = rsp_data.level_offset;
  assign rsp.level_size     = rsp_data.level_size;
  assign rsp.element_offset = rsp_data.element_offset;
  assign rsp.total_size     = rsp_data.total_size;
  assign rsp.out_of_range   = rsp_data.out_of_range;

  // No request transaction while the level table is stale
  `MLAC_ASSERT_NOW(a_no_req_while_building, req.valid && req.ready, tbl_stat.ready)
  // A configuration write always triggers a rebuild
  `MLAC_ASSERT_NEXT(a_cfg_starts_build, cfg_wr, !tbl_stat.ready)
  // Once built, the table stays valid until the next write
  `MLAC_ASSERT_NEXT(a_table_stays_ready, tbl_stat.ready && !cfg_wr, tbl_stat.ready)

endmodule
